@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; clocked, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ sv/anbs_pkg.sv @@
// ----------------------------------------------------------------------------
// anbs_pkg
// Types and constants shared by the Annex B NAL splitter modules.
// ----------------------------------------------------------------------------
package anbs_pkg;

	localparam int RUN_BITS_DEF    = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// Command queue between classifier and result generator
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	// Result kinds as seen on the kind port
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_RUN   = 2'd1,
		KIND_START = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	// Classified item; each expands into an optional lead result and a main one
	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,  // lead: zero run, main: payload byte
		OP_START = 2'd1,  // lead: NAL end,  main: NAL start
		OP_EOS   = 2'd2   // lead: zero run, main: NAL end
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        lead;
		logic [7:0]  data;
		logic [15:0] run;
		logic        ovf;
		logic [31:0] offset;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload;
		logic [15:0] run;
		logic        ovf;
		logic [31:0] offset;
		logic        last;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic mid_entry;
		logic out_valid;
	} bk_stat_t;

endpackage

@@ sv/anbs_front.sv @@
// ----------------------------------------------------------------------------
// anbs_front
// Byte classifier: tracks the zero run and NAL state, emits queue commands.
// ----------------------------------------------------------------------------
module anbs_front #(
	parameter int RUN_BITS    = anbs_pkg::RUN_BITS_DEF,
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                end_of_stream,
	output logic                cmd_push,
	output anbs_pkg::cmd_t      cmd
);

	localparam int RUN_EXT = (RUN_BITS > 16) ? RUN_BITS : 16;
	localparam int OFF_EXT = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
	localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

	logic [RUN_BITS-1:0]    zero_run_q;
	logic                   run_sat_q;
	logic [OFFSET_BITS-1:0] byte_offset_q;
	logic [OFFSET_BITS-1:0] run_start_q;
	logic                   nal_open_q;

	logic                   is_zero;
	logic                   is_start;
	logic                   run_pending;
	logic [RUN_EXT-1:0]     run_ext;
	logic [OFF_EXT-1:0]     off_ext;
	logic [OFFSET_BITS-1:0] offset_inc;

	assign run_pending = (zero_run_q != '0);
	assign is_zero     = !end_of_stream && (data_byte == 8'h00);
	assign is_start    = !end_of_stream && (data_byte == 8'h01) &&
		(zero_run_q >= RUN_BITS'(2));
	assign run_ext     = RUN_EXT'(zero_run_q);
	assign off_ext     = OFF_EXT'(run_start_q);
	assign offset_inc  = byte_offset_q + OFFSET_BITS'(1);

	always_comb begin
		cmd.data   = data_byte;
		cmd.run    = run_ext[15:0];
		cmd.ovf    = run_sat_q;
		cmd.offset = off_ext[31:0];
		if (end_of_stream) begin
			cmd.op   = anbs_pkg::OP_EOS;
			cmd.lead = run_pending;
			cmd_push = take && nal_open_q;
		end else if (is_start) begin
			cmd.op   = anbs_pkg::OP_START;
			cmd.lead = nal_open_q;
			cmd_push = take;
		end else begin
			cmd.op   = anbs_pkg::OP_BYTE;
			cmd.lead = run_pending;
			cmd_push = take && !is_zero && nal_open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q    <= '0;
			run_sat_q     <= 1'b0;
			byte_offset_q <= '0;
			run_start_q   <= '0;
			nal_open_q    <= 1'b0;
		end else if (take) begin
			if (end_of_stream) begin
				// flush: offset holds, NAL closes
				zero_run_q <= '0;
				run_sat_q  <= 1'b0;
				nal_open_q <= 1'b0;
			end else if (is_zero) begin
				if (!run_pending) begin
					run_start_q <= byte_offset_q;
				end
				if (zero_run_q == RUN_MAX) begin
					run_sat_q <= 1'b1;
				end else begin
					zero_run_q <= zero_run_q + RUN_BITS'(1);
				end
				byte_offset_q <= offset_inc;
			end else begin
				if (is_start) begin
					nal_open_q <= 1'b1;
				end
				zero_run_q    <= '0;
				run_sat_q     <= 1'b0;
				byte_offset_q <= offset_inc;
			end
		end
	end

endmodule

@@ sv/anbs_queue.sv @@
// ----------------------------------------------------------------------------
// anbs_queue
// Small FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module anbs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  anbs_pkg::cmd_t    wdata,
	input  logic              rd,
	output anbs_pkg::cmd_t    head,
	output anbs_pkg::q_stat_t stat
);

	anbs_pkg::cmd_t                     mem_q [anbs_pkg::QDEPTH];
	logic [anbs_pkg::QPTR_BITS-1:0]     wptr_q;
	logic [anbs_pkg::QPTR_BITS-1:0]     rptr_q;
	logic [anbs_pkg::QCNT_BITS-1:0]     count_q;

	assign stat.full  = (count_q == anbs_pkg::QCNT_BITS'(anbs_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == anbs_pkg::QPTR_BITS'(anbs_pkg::QDEPTH - 1)) ?
					'0 : wptr_q + anbs_pkg::QPTR_BITS'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == anbs_pkg::QPTR_BITS'(anbs_pkg::QDEPTH - 1)) ?
					'0 : rptr_q + anbs_pkg::QPTR_BITS'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + anbs_pkg::QCNT_BITS'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - anbs_pkg::QCNT_BITS'(1);
			end
		end
	end

endmodule

@@ sv/anbs_back.sv @@
// ----------------------------------------------------------------------------
// anbs_back
// Result generator: expands each command into one or two results.
// ----------------------------------------------------------------------------
module anbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  anbs_pkg::cmd_t     head,
	input  logic               head_valid,
	output logic               head_pop,
	input  logic               out_take,
	output anbs_pkg::res_t     res,
	output anbs_pkg::bk_stat_t stat
);

	logic           mid_q;
	logic           out_valid_q;
	anbs_pkg::res_t res_q;
	anbs_pkg::res_t res_d;
	logic           load;
	logic           lead_now;

	assign load     = head_valid && (!out_valid_q || out_take);
	assign lead_now = head.lead && !mid_q;
	assign head_pop = load && !lead_now;

	always_comb begin
		res_d.kind    = anbs_pkg::KIND_END;
		res_d.payload = '0;
		res_d.run     = '0;
		res_d.ovf     = 1'b0;
		res_d.offset  = '0;
		res_d.last    = !lead_now;
		case (head.op)
			anbs_pkg::OP_BYTE: begin
				if (lead_now) begin
					res_d.kind = anbs_pkg::KIND_RUN;
					res_d.run  = head.run;
					res_d.ovf  = head.ovf;
				end else begin
					res_d.kind    = anbs_pkg::KIND_BYTE;
					res_d.payload = head.data;
				end
			end
			anbs_pkg::OP_START: begin
				if (!lead_now) begin
					res_d.kind   = anbs_pkg::KIND_START;
					res_d.run    = head.run;
					res_d.ovf    = head.ovf;
					res_d.offset = head.offset;
				end
			end
			anbs_pkg::OP_EOS: begin
				if (lead_now) begin
					res_d.kind = anbs_pkg::KIND_RUN;
					res_d.run  = head.run;
					res_d.ovf  = head.ovf;
				end
			end
			default: begin
				res_d.kind = anbs_pkg::KIND_END;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mid_q       <= lead_now;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res            = res_q;
	assign stat.mid_entry = mid_q;
	assign stat.out_valid = out_valid_q;

endmodule

@@ sv/annexb_nal_splitter_top.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_splitter_top - Annex B start-code scanner and NAL splitter
// Requests pass through the command queue to the back part's output register.
// Throughput: one request per cycle while full is low; full rises only while
// the four-entry command queue is full, when the result side falls behind.
// Results leave at one per cycle while popped; a lead (run or NAL end) makes two.
// Reset clears the zero run, offsets, NAL state, command queue and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_splitter_top #(
	parameter int RUN_BITS    = anbs_pkg::RUN_BITS_DEF,
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  payload,
	output logic [15:0] run_length,
	output logic        run_overflow,
	output logic [31:0] nal_offset,
	output logic        last_of_item
);

	// Front part: classifies each request against the zero run and NAL state
	// and posts at most one command. Back part: expands a command into an optional lead
	// result (zero run or NAL end) and a main result. The command queue lets
	// the front keep taking bytes while the back drains a two-result burst.

	logic               take;
	logic               out_take;
	logic               cmd_push;
	anbs_pkg::cmd_t     cmd;
	anbs_pkg::cmd_t     q_head;
	anbs_pkg::q_stat_t  q_stat;
	logic               q_pop;
	anbs_pkg::res_t     res;
	anbs_pkg::bk_stat_t bk_stat;

	// Hold off new requests only while the command queue is full.
	assign full     = q_stat.full;
	assign take     = push && !q_stat.full;
	assign empty    = !bk_stat.out_valid;
	assign out_take = pop && bk_stat.out_valid;

	anbs_front #(
		.RUN_BITS    (RUN_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cmd_push      (cmd_push),
		.cmd           (cmd)
	);

	anbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd),
		.rd     (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	anbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_stat.empty),
		.head_pop   (q_pop),
		.out_take   (out_take),
		.res        (res),
		.stat       (bk_stat)
	);

	// Drive the result ports straight from the back part's output register.
	assign kind         = res.kind;
	assign payload      = res.payload;
	assign run_length   = res.run;
	assign run_overflow = res.ovf;
	assign nal_offset   = res.offset;
	assign last_of_item = res.last;

	// A command is posted only when the queue has room.
	`ASSERT_IMP(a_push_room, clk, arst_n, cmd_push, !q_stat.full, "command posted to full queue")
	// The back part retires only entries that are present.
	`ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, !q_stat.empty, "command retired from empty queue")
	// Halfway through an entry, that entry must still be at the head.
	`ASSERT_IMP(a_mid_head, clk, arst_n, bk_stat.mid_entry, !q_stat.empty, "lead result without entry")
	// Retiring an entry starts the next one fresh.
	`ASSERT_NXT(a_pop_fresh, clk, arst_n, q_pop, !bk_stat.mid_entry, "entry retired mid-way")

endmodule
